/* rtl/core/sqs_pkg.sv */
`default_nettype none

package sqs_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int STAT_W = 3;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND     = 2'd3;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
    } sqs_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } sqs_res_t;

    // per-cell controls
    typedef struct packed {
        logic load;
        logic shift;
    } sqs_cell_ctl_t;

    // controller -> chain
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] rd_idx;
    } sqs_chain_ctl_t;

    // chain -> controller
    typedef struct packed {
        logic signed [DATA_W-1:0] head;
        logic signed [DATA_W-1:0] rd_data;
        logic                     hit;
        logic [IDX_W-1:0]         hit_pos;
    } sqs_chain_sts_t;

endpackage

`default_nettype wire

/* rtl/core/sqs_cell.sv */
`default_nettype none

module sqs_cell
    import sqs_pkg::*;
(
    input  wire logic                     clk,
    input  wire sqs_cell_ctl_t            ctl,
    input  wire logic signed [DATA_W-1:0] wr_data,
    input  wire logic signed [DATA_W-1:0] neighbour,
    input  wire logic signed [DATA_W-1:0] probe,
    output logic signed [DATA_W-1:0]      data,
    output logic                          match
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift)
        begin
            data_next = neighbour;
        end
        else if (ctl.load)
        begin
            data_next = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == probe);

endmodule

`default_nettype wire

/* rtl/core/sqs_chain.sv */
`default_nettype none

module sqs_chain
    import sqs_pkg::*;
(
    input  wire logic                     clk,
    input  wire sqs_chain_ctl_t           ctl,
    input  wire logic signed [DATA_W-1:0] value,
    output sqs_chain_sts_t                sts
);

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]         cell_hit;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(i);
            localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(i);

            sqs_cell_ctl_t            cctl;
            logic signed [DATA_W-1:0] nbr;
            logic                     m;

            assign cctl = '{load:  ctl.ins && (ctl.count[IDX_W-1:0] == MY_IDX),
                            shift: ctl.del};

            // top cell keeps its own word on a shift; it lies above count anyway
            if (i == DEPTH - 1)
            begin : g_top
                assign nbr = cell_data[i];
            end
            else
            begin : g_mid
                assign nbr = cell_data[i+1];
            end

            sqs_cell u_cell (
                .clk       (clk),
                .ctl       (cctl),
                .wr_data   (value),
                .neighbour (nbr),
                .probe     (value),
                .data      (cell_data[i]),
                .match     (m)
            );

            assign cell_hit[i] = m && (MY_CNT < ctl.count);
        end
    endgenerate

    // newest match wins
    always_comb
    begin
        sts.head    = cell_data[0];
        sts.rd_data = cell_data[ctl.rd_idx];
        sts.hit     = |cell_hit;
        sts.hit_pos = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (cell_hit[k])
            begin
                sts.hit_pos = IDX_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/shift_queue_with_search.sv */
// Insert, delete and find: result strobed in the cycle after the start beat,
// and a new beat may follow in the next cycle (one item per cycle).
// Traverse of n stored entries: n result beats in consecutive cycles, the first
// in the cycle after start; busy rises with the first beat, drops with the last.
// The listing walks one cell of the chain per cycle through the read select.
// Reset clears the count and the listing state; the word cells are not cleared.
`default_nettype none

module shift_queue_with_search
    import sqs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire sqs_req_t request,
    output logic          busy,
    output logic          result_valid,
    output sqs_res_t      result
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             trav_reg, trav_next;
    logic [IDX_W-1:0] tidx_reg, tidx_next;
    logic             strobe_reg, strobe_next;
    sqs_res_t         res_reg, res_next;

    sqs_chain_ctl_t   cctl;
    sqs_chain_sts_t   csts;

    logic             accept;
    logic [CNT_W-1:0] cnt_dec;

    assign accept  = start && !trav_reg;
    assign cnt_dec = count_reg - CNT_W'(1);

    sqs_chain u_chain (
        .clk   (clk),
        .ctl   (cctl),
        .value (request.value),
        .sts   (csts)
    );

    // chain controls; the newest entry is read on the traverse start beat
    always_comb
    begin
        cctl.ins    = accept && (request.command == CMD_INSERT)
                      && (count_reg != CNT_W'(DEPTH));
        cctl.del    = accept && (request.command == CMD_DELETE) && (count_reg != '0);
        cctl.count  = count_reg;
        cctl.rd_idx = trav_reg ? tidx_reg : cnt_dec[IDX_W-1:0];
    end

    always_comb
    begin
        count_next   = count_reg;
        trav_next    = trav_reg;
        tidx_next    = tidx_reg;
        strobe_next  = 1'b0;
        res_next     = '0;

        if (trav_reg)
        begin
            strobe_next       = 1'b1;
            res_next.status   = ST_FOUND;
            res_next.position = POS_W'(tidx_reg);
            res_next.data     = csts.rd_data;
            res_next.last     = (tidx_reg == '0);
            trav_next         = (tidx_reg != '0);
            tidx_next         = tidx_reg - IDX_W'(1);
        end
        else if (accept)
        begin
            strobe_next   = 1'b1;
            res_next.last = 1'b1;
            unique case (request.command)
                CMD_INSERT:
                begin
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        res_next.status   = ST_INSERTED;
                        res_next.position = POS_W'(count_reg[IDX_W-1:0]);
                        count_next        = count_reg + CNT_W'(1);
                    end
                end
                CMD_DELETE:
                begin
                    if (count_reg == '0)
                    begin
                        res_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        res_next.status = ST_DELETED;
                        res_next.data   = csts.head;
                        count_next      = cnt_dec;
                    end
                end
                CMD_TRAVERSE:
                begin
                    if (count_reg == '0)
                    begin
                        res_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        // newest entry goes out on this beat, the rest follow
                        res_next.status   = ST_FOUND;
                        res_next.position = POS_W'(cnt_dec[IDX_W-1:0]);
                        res_next.data     = csts.rd_data;
                        res_next.last     = (cnt_dec == '0);
                        trav_next         = (cnt_dec != '0);
                        tidx_next         = cnt_dec[IDX_W-1:0] - IDX_W'(1);
                    end
                end
                CMD_FIND:
                begin
                    if (csts.hit)
                    begin
                        res_next.status   = ST_FOUND;
                        res_next.position = POS_W'(csts.hit_pos);
                    end
                    else
                    begin
                        res_next.status = ST_NOTFOUND;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            trav_reg   <= 1'b0;
            tidx_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            trav_reg   <= trav_next;
            tidx_reg   <= tidx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy         = trav_reg;
    assign result_valid = strobe_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

/* rtl/core/sqs_checker.sv */
`default_nettype none

module sqs_checker
    import sqs_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     result_valid,
    input wire sqs_res_t result
);

    // every accepted beat answers in the next cycle
    a_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> result_valid)
        else $error("no result after accepted beat");

    // while listing, a non-final beat is on the outputs
    a_busy_listing: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (result_valid && !result.last))
        else $error("busy without a listing beat");

    // listing ends on the final beat
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && result.last))
        else $error("listing ended without final beat");

    // a non-final beat is always followed by another
    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> result_valid)
        else $error("result sequence broken");

endmodule

bind shift_queue_with_search sqs_checker u_sqs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

/* verif/tb_shift_queue_with_search.sv */
`timescale 1ns / 1ps

module tb_shift_queue_with_search;
    import sqs_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    sqs_req_t request = '0;
    logic     busy;
    logic     result_valid;
    sqs_res_t result;

    sqs_req_t pending_beats[$];
    sqs_res_t due_results[$];
    logic signed [DATA_W-1:0] recent_values[$];

    // shadow copy of the queue contents
    logic signed [DATA_W-1:0] shadow_words[DEPTH];
    int shadow_fill = 0;

    int issued_total = 0;
    int accepted_total = 0;
    int mismatches = 0;
    int burst_left = 1;
    int gap_left = 0;

    shift_queue_with_search u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Works out the result beats of one accepted command and updates the shadow queue.
    function automatic void apply_queue_command(input sqs_req_t req);
        sqs_res_t r;
        int       i;
        bit       hit;
        r = '0;
        r.last = 1'b1;
        hit = 1'b0;
        case (req.command)
            CMD_INSERT:
            begin
                if (shadow_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_fill] = req.value;
                    r.status = ST_INSERTED;
                    r.position = POS_W'(shadow_fill);
                    shadow_fill++;
                end
                due_results.push_back(r);
            end
            CMD_DELETE:
            begin
                if (shadow_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.status = ST_DELETED;
                    r.data = shadow_words[0];
                    for (i = 0; i + 1 < shadow_fill; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_fill--;
                end
                due_results.push_back(r);
            end
            CMD_TRAVERSE:
            begin
                if (shadow_fill == 0)
                begin
                    r.status = ST_EMPTY;
                    due_results.push_back(r);
                end
                else
                begin
                    // newest first, last flag on the head entry
                    for (i = shadow_fill - 1; i >= 0; i--)
                    begin
                        r.status = ST_FOUND;
                        r.position = POS_W'(i);
                        r.data = shadow_words[i];
                        r.last = (i == 0);
                        due_results.push_back(r);
                    end
                end
            end
            default:
            begin
                r.status = ST_NOTFOUND;
                for (i = shadow_fill - 1; i >= 0; i--)
                begin
                    if (!hit && shadow_words[i] == req.value)
                    begin
                        hit = 1'b1;
                        r.status = ST_FOUND;
                        r.position = POS_W'(i);
                    end
                end
                due_results.push_back(r);
            end
        endcase
    endfunction

    task automatic push_beat(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] v);
        sqs_req_t b;
        b.command = cmd;
        b.value = v;
        pending_beats.push_back(b);
        if (cmd == CMD_INSERT)
        begin
            recent_values.push_back(v);
            if (recent_values.size() > 24)
                void'(recent_values.pop_front());
        end
    endtask

    // About four in ten are recently inserted values so that finds hit; the rest full-range or extremes.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4 && recent_values.size() > 0)
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
        else if (roll == 4)
            return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else if (roll == 5)
            return $urandom_range(0, 1) ? 32'sh0 : -32'sh1;
        else
            return $urandom;
    endfunction

    task automatic report_mismatch(input string what, input sqs_res_t exp, input sqs_res_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: exp st=%0d pos=%0d data=%h last=%0d, got st=%0d pos=%0d data=%h last=%0d",
                     $time, what, exp.status, exp.position, exp.data, exp.last,
                     got.status, got.position, got.data, got.last);
    endtask

    // driver: bursts of beats with random gaps, start held until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_queue_command(request);
                accepted_total <= accepted_total + 1;
            end
            if (start && busy)
                ; // beat held until accepted
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                start <= 1'b1;
                request <= pending_beats.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 10);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: every strobed beat is checked against the oldest due result
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (due_results.size() == 0)
                report_mismatch("unexpected beat", '0, result);
            else
            begin
                if (result.status !== due_results[0].status
                    || result.position !== due_results[0].position
                    || result.data !== due_results[0].data
                    || result.last !== due_results[0].last)
                    report_mismatch("wrong beat", due_results[0], result);
                void'(due_results.pop_front());
            end
        end
    end

    initial
    begin
        int k;
        int blk;
        int mode;
        int roll;
        int blk_len;
        logic [CMD_W-1:0] cmd;

        // directed: empty cases, extremes, full queue, duplicate search
        push_beat(CMD_FIND, 32'sd5);
        push_beat(CMD_TRAVERSE, 32'sd0);
        push_beat(CMD_DELETE, -32'sd1);
        push_beat(CMD_INSERT, 32'sh8000_0000);
        push_beat(CMD_INSERT, 32'sh7fff_ffff);
        push_beat(CMD_INSERT, -32'sd1);
        push_beat(CMD_INSERT, 32'sd0);
        push_beat(CMD_FIND, 32'sh8000_0000);
        push_beat(CMD_FIND, 32'sd12345);
        push_beat(CMD_TRAVERSE, 32'sh7fff_ffff);
        for (k = 0; k < DEPTH - 4; k++)
            push_beat(CMD_INSERT, (k % 3 == 0) ? 32'sh7fff_ffff : $urandom);
        push_beat(CMD_INSERT, 32'sd1);
        push_beat(CMD_TRAVERSE, 32'sd0);
        push_beat(CMD_FIND, 32'sh7fff_ffff);
        push_beat(CMD_DELETE, 32'sd0);

        // random: blocks biased to fill, drain or mix so both ends are reached
        for (blk = 0; blk < 14; blk++)
        begin
            mode = $urandom_range(0, 2);
            blk_len = $urandom_range(25, 45);
            for (k = 0; k < blk_len; k++)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0: cmd = (roll < 60) ? CMD_INSERT : (roll < 75) ? CMD_DELETE
                           : (roll < 85) ? CMD_TRAVERSE : CMD_FIND;
                    1: cmd = (roll < 15) ? CMD_INSERT : (roll < 75) ? CMD_DELETE
                           : (roll < 85) ? CMD_TRAVERSE : CMD_FIND;
                    default: cmd = (roll < 35) ? CMD_INSERT : (roll < 65) ? CMD_DELETE
                                 : (roll < 75) ? CMD_TRAVERSE : CMD_FIND;
                endcase
                push_beat(cmd, pick_value());
            end
        end
        issued_total = pending_beats.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_total < issued_total)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
